// File: rtl/core/sensor_reply_frame_parser_assert.svh
// assertion macros used by the checker file
`ifndef SENSOR_REPLY_FRAME_PARSER_ASSERT_SVH
`define SENSOR_REPLY_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SRFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srfp assertion failed");

// next-cycle implication, disabled while in reset
`define SRFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srfp assertion failed");

// next-cycle implication that also checks across reset
`define SRFP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("srfp assertion failed");

`endif

// File: rtl/core/srfp_pkg.sv
// types, constants and the crc byte update of the sensor reply frame parser
package srfp_pkg;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  HEADER_RESET = 8'hC0;
    localparam int          FRAME_LEN    = 9;
    localparam int          CRC_LEN      = 7;
    localparam int          POS_W        = 4;

    localparam logic [POS_W-1:0] POS_FIRST = 4'd0;
    localparam logic [POS_W-1:0] POS_CRC   = 4'(CRC_LEN);
    localparam logic [POS_W-1:0] POS_LAST  = 4'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_END   = 4'(FRAME_LEN);

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_BAD_CRC    = 2'd2;

    localparam logic REG_HEADER = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } srfp_in_t;

    typedef struct packed {
        logic [15:0] pm25_tenths;
        logic [15:0] pm10_tenths;
        logic [1:0]  frame_status;
    } srfp_out_t;

    // control from the frame logic to the crc accumulator
    typedef struct packed {
        logic       enable;
        logic       restart;
        logic       feed;
        logic       finish;
        logic [7:0] data;
    } srfp_crc_ctl_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/srfp_cfg.sv
// apb register block holding the expected header byte
module srfp_cfg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  expected_header
);
    import srfp_pkg::*;

    logic [7:0] header_reg;
    logic [7:0] header_next;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_HEADER);

    always_comb begin
        header_next = header_reg;
        if (wr_hit) begin
            header_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
        end else begin
            header_reg <= header_next;
        end
    end

    assign prdata = (paddr[2] == REG_HEADER) ? {24'h000000, header_reg} : 32'h00000000;
    assign expected_header = header_reg;

endmodule

// File: rtl/core/srfp_crc.sv
// running crc-16 accumulator, one byte per cycle while ctl.enable and ctl.feed are high
module srfp_crc (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  srfp_pkg::srfp_crc_ctl_t ctl,
    output logic [15:0]             crc
);
    import srfp_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] base;

    assign base = ctl.restart ? CRC_INIT : crc_reg;

    always_comb begin
        crc_next = crc_reg;
        if (ctl.enable) begin
            if (ctl.finish) begin
                crc_next = CRC_INIT;
            end else if (ctl.feed) begin
                crc_next = crc_byte(base, ctl.data);
            end else begin
                crc_next = base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

// File: rtl/core/srfp_frame.sv
// byte position, frame store, frame checks and the result register
module srfp_frame (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  srfp_pkg::srfp_in_t      s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output srfp_pkg::srfp_out_t     m_data,
    input  logic [7:0]              expected_header,
    input  logic [15:0]             crc,
    output srfp_pkg::srfp_crc_ctl_t crc_ctl
);
    import srfp_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_eff;
    logic [7:0]       store_reg [0:FRAME_LEN-2];
    logic [15:0]      last_pm25_reg;
    logic [15:0]      last_pm10_reg;
    logic [15:0]      last_pm25_next;
    logic [15:0]      last_pm10_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    srfp_out_t        m_data_reg;
    srfp_out_t        m_data_next;
    logic             accept;
    logic             last_byte;
    logic [15:0]      rx_crc;
    logic [1:0]       status;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // a start flag or a wrapped position begins a new frame
    assign pos_eff   = (s_data.frame_start || pos_reg >= POS_END) ? POS_FIRST : pos_reg;
    assign last_byte = (pos_eff == POS_LAST);
    assign rx_crc    = {s_data.data_byte, store_reg[7]};

    assign crc_ctl.enable  = accept;
    assign crc_ctl.restart = (pos_eff == POS_FIRST);
    assign crc_ctl.feed    = (pos_eff < POS_CRC);
    assign crc_ctl.finish  = last_byte;
    assign crc_ctl.data    = s_data.data_byte;

    always_comb begin
        if (store_reg[0] != expected_header) begin
            status = ST_BAD_HEADER;
        end else if (crc != rx_crc) begin
            status = ST_BAD_CRC;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        pos_next       = pos_reg;
        last_pm25_next = last_pm25_reg;
        last_pm10_next = last_pm10_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        if (accept) begin
            if (last_byte) begin
                pos_next = POS_FIRST;
                if (status == ST_OK) begin
                    last_pm25_next = {store_reg[3], store_reg[4]};
                    last_pm10_next = {store_reg[5], store_reg[6]};
                end
                m_valid_next             = 1'b1;
                m_data_next.pm25_tenths  = last_pm25_next;
                m_data_next.pm10_tenths  = last_pm10_next;
                m_data_next.frame_status = status;
            end else begin
                pos_next = pos_eff + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_FIRST;
            last_pm25_reg <= 16'h0000;
            last_pm10_reg <= 16'h0000;
            m_valid_reg   <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            last_pm25_reg <= last_pm25_next;
            last_pm10_reg <= last_pm10_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // store bytes 0 to 7, the ninth byte is used straight from the input
    always_ff @(posedge aclk) begin
        if (accept && !last_byte) begin
            store_reg[pos_eff[2:0]] <= s_data.data_byte;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/sensor_reply_frame_parser.sv
// a result shows on m_valid in the cycle after the ninth byte of a frame is taken
// throughput: one byte per cycle while input is not stopped, as the unrolled crc byte update is combinational
// a held result stops input only while it waits on m_ready
// reset (aresetn low, synchronous): position 0, crc 0xFFFF, readings 0, header 0xC0
// the frame store holds no reset and is always written before it is read
module sensor_reply_frame_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  srfp_pkg::srfp_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output srfp_pkg::srfp_out_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import srfp_pkg::*;

    logic [7:0]    expected_header;
    logic [15:0]   crc;
    srfp_crc_ctl_t crc_ctl;

    srfp_cfg u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .expected_header (expected_header)
    );

    srfp_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (crc_ctl),
        .crc     (crc)
    );

    srfp_frame u_frame (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .expected_header (expected_header),
        .crc             (crc),
        .crc_ctl         (crc_ctl)
    );

endmodule

// File: rtl/core/srfp_checker.sv
// port-level checks of the sensor reply frame parser and their bind
`include "sensor_reply_frame_parser_assert.svh"

module srfp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input srfp_pkg::srfp_out_t m_data,
    input logic                pready
);
    import srfp_pkg::*;

    `SRFP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `SRFP_ASSERT_NOW(a_status_code, aclk, aresetn, m_valid, m_data.frame_status <= ST_BAD_CRC)
    `SRFP_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `SRFP_ASSERT_NOW(a_pready_high, aclk, aresetn, 1'b1, pready)
    `SRFP_ASSERT_NEXT_ALWAYS(a_reset_clears_out, aclk, !aresetn, !m_valid)

endmodule

bind sensor_reply_frame_parser srfp_checker u_srfp_checker (.*);
